// ----- src/tcw_pkg.sv -----
// Shared constants, payload types and control types of the text console writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int CUR_W = $clog2(CELL_COUNT);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int IDX_EXT_W = ((CUR_W > INDEX_W) ? CUR_W : INDEX_W) + 1;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   character;
        logic [INDEX_W-1:0]  cell_index;
    } request_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [CHAR_W-1:0]   read_character;
        logic [ATTR_W-1:0]   read_attribute;
        logic                scrolled;
    } result_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_BLANK
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill;
        logic fill_reset;
        logic copy;
        logic cnt_clear;
        logic cnt_inc;
        logic finish;
        logic sel_read;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scroll_req;
        logic cnt_last;
        logic cnt_copy_end;
    } dp_status_t;

endpackage

// ----- src/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
module tcw_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tcw_pkg::ACTION_W-1:0]      action,
    input  tcw_pkg::dp_status_t               status,
    output tcw_pkg::ctrl_cmd_t                cmd,
    output logic                              busy
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::S_INIT:
            begin
                if (status.cnt_last)
                begin
                    state_next = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        tcw_pkg::ACT_READ:  state_next = tcw_pkg::S_READ;
                        tcw_pkg::ACT_CLEAR: state_next = tcw_pkg::S_CLEAR;
                        tcw_pkg::ACT_PUT:
                        begin
                            if (status.scroll_req)
                            begin
                                state_next = tcw_pkg::S_SCROLL;
                            end
                        end
                        default: state_next = tcw_pkg::S_IDLE;
                    endcase
                end
            end
            tcw_pkg::S_READ:
            begin
                state_next = tcw_pkg::S_IDLE;
            end
            tcw_pkg::S_CLEAR:
            begin
                if (status.cnt_last)
                begin
                    state_next = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_SCROLL:
            begin
                if (status.cnt_copy_end)
                begin
                    state_next = tcw_pkg::S_BLANK;
                end
            end
            tcw_pkg::S_BLANK:
            begin
                if (status.cnt_last)
                begin
                    state_next = tcw_pkg::S_IDLE;
                end
            end
            default: state_next = tcw_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            tcw_pkg::S_INIT:
            begin
                cmd.fill       = 1'b1;
                cmd.fill_reset = 1'b1;
                cmd.cnt_inc    = 1'b1;
            end
            tcw_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept    = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    case (action)
                        tcw_pkg::ACT_READ:  cmd.finish = 1'b0;
                        tcw_pkg::ACT_CLEAR: cmd.finish = 1'b0;
                        tcw_pkg::ACT_PUT:   cmd.finish = !status.scroll_req;
                        default:            cmd.finish = 1'b1;
                    endcase
                end
            end
            tcw_pkg::S_READ:
            begin
                cmd.finish   = 1'b1;
                cmd.sel_read = 1'b1;
            end
            tcw_pkg::S_CLEAR:
            begin
                cmd.fill    = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.finish  = status.cnt_last;
            end
            tcw_pkg::S_SCROLL:
            begin
                cmd.copy    = 1'b1;
                cmd.cnt_inc = !status.cnt_copy_end;
            end
            tcw_pkg::S_BLANK:
            begin
                cmd.fill    = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.finish  = status.cnt_last;
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

// ----- src/tcw_dp.sv -----
// Datapath of the text console writer: cursor, sweep counter, screen store, result.
module tcw_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::request_t             request,
    input  logic                          cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata,
    input  tcw_pkg::ctrl_cmd_t            cmd,
    output tcw_pkg::dp_status_t           status,
    output tcw_pkg::result_t              result,
    output logic                          done
);

    logic [tcw_pkg::CUR_W-1:0]     cur_reg, cur_next;
    logic [tcw_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]     col_reg, col_next;
    logic [tcw_pkg::CUR_W-1:0]     cnt_reg, cnt_next;
    logic [tcw_pkg::ATTR_W-1:0]    attr_reg;
    logic                          scroll_flag_reg;
    logic                          in_range_reg;
    logic                          done_reg;
    tcw_pkg::result_t              result_reg, result_next;

    logic                          put_active;
    logic                          is_newline;
    logic                          col_last;
    logic                          row_last;
    logic                          wrap;
    logic [tcw_pkg::IDX_EXT_W-1:0] idx_ext;
    logic                          idx_in_range;

    logic                          ram_we;
    logic [tcw_pkg::CUR_W-1:0]     ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
    logic [tcw_pkg::CUR_W-1:0]     ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_rdata;
    logic [tcw_pkg::ATTR_W-1:0]    fill_attr;

    assign put_active = (request.action == tcw_pkg::ACT_PUT) && (request.character != '0);
    assign is_newline = (request.character == tcw_pkg::NEWLINE_CHAR);
    assign col_last   = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign row_last   = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign wrap       = is_newline || col_last;
    assign idx_ext    = tcw_pkg::IDX_EXT_W'(request.cell_index);
    assign idx_in_range = (idx_ext < tcw_pkg::IDX_EXT_W'(tcw_pkg::CELL_COUNT));

    assign status.scroll_req   = put_active && wrap && row_last;
    assign status.cnt_last     = (cnt_reg == tcw_pkg::CUR_W'(tcw_pkg::CELL_COUNT - 1));
    assign status.cnt_copy_end =
        (cnt_reg == tcw_pkg::CUR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS));

    always_comb
    begin
        cur_next = cur_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.accept)
        begin
            case (request.action)
                tcw_pkg::ACT_PUT:
                begin
                    if (put_active)
                    begin
                        if (wrap)
                        begin
                            col_next = '0;
                            if (row_last)
                            begin
                                cur_next = cur_reg - tcw_pkg::CUR_W'(col_reg);
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                cur_next = cur_reg - tcw_pkg::CUR_W'(col_reg)
                                         + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                            cur_next = cur_reg + 1'b1;
                        end
                    end
                end
                tcw_pkg::ACT_CLEAR:
                begin
                    cur_next = '0;
                    row_next = '0;
                    col_next = '0;
                end
                default:
                begin
                    cur_next = cur_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            cnt_reg         <= '0;
            attr_reg        <= tcw_pkg::RESET_ATTR;
            scroll_flag_reg <= 1'b0;
            in_range_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            cur_reg  <= cur_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                scroll_flag_reg <= status.scroll_req;
                in_range_reg    <= idx_in_range;
            end
        end
    end

    assign fill_attr = cmd.fill_reset ? tcw_pkg::RESET_ATTR : attr_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = {fill_attr, tcw_pkg::SPACE_CHAR};
        if (cmd.fill)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.copy && (cnt_reg != '0))
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg - 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (cmd.accept && put_active && !is_newline)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_reg;
            ram_wdata = {attr_reg, request.character};
        end
    end

    assign ram_raddr = cmd.accept ? idx_ext[tcw_pkg::CUR_W-1:0]
                                  : cnt_reg + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        result_next.cursor_cell    = tcw_pkg::CURSOR_W'(cur_next);
        result_next.read_character = '0;
        result_next.read_attribute = '0;
        result_next.scrolled       = !cmd.accept && scroll_flag_reg;
        if (cmd.sel_read && in_range_reg)
        begin
            result_next.read_character = ram_rdata[tcw_pkg::CHAR_W-1:0];
            result_next.read_attribute = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ----- src/text_console_writer_unit.sv -----
// Top level of the text console writer: controller plus datapath.
//
// A transaction is accepted on a rising edge with start high and busy low;
// request carries action, character and cell_index. Each transaction gives
// exactly one result, shown on result for one cycle with done high, in the
// cycle after the transaction finishes. The receiver cannot stall.
// Controller states passed from acceptance until the transaction finishes:
//   put without scroll, newline without scroll, zero character, unused action: S_IDLE only
//   read: S_READ (registered read of the screen store)
//   clear: S_CLEAR (one cell written per cycle)
//   put or newline that scrolls: S_SCROLL, then S_BLANK (row copy through the one
//   read and one write port of the screen store, then the bottom row blanked)
// A new transaction may start in the cycle in which done is high.
// cfg_we writes cfg_wdata into the attribute register at any rising edge.
// After reset the block sweeps the screen store with spaces of attribute 15,
// one cell per cycle through all CELL_COUNT (2000) cells, with busy high; the cursor
// is at cell 0 and the attribute register holds 15.
module text_console_writer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tcw_pkg::request_t           request,
    output logic                        done,
    output tcw_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata
);

    tcw_pkg::ctrl_cmd_t  cmd;
    tcw_pkg::dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tcw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

// ----- verif/tb_text_console_writer_unit.sv -----
// Self-checking testbench for the text console writer: screen mirror, stimulus and result checks.
module tb_text_console_writer_unit;

    localparam logic [tcw_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 290;
    localparam longint CYCLE_LIMIT = 20_000_000;

    class console_mirror;
        logic [tcw_pkg::CELL_W-1:0] cells [tcw_pkg::CELL_COUNT];
        int                         cursor;
        logic [tcw_pkg::ATTR_W-1:0] attr;
        tcw_pkg::result_t           due_results [$];
        int                         errors;

        function new();
            foreach (cells[i])
                cells[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CHAR};
            cursor = 0;
            attr   = tcw_pkg::RESET_ATTR;
            errors = 0;
        endfunction

        function void apply_request(tcw_pkg::request_t r);
            tcw_pkg::result_t outcome;
            outcome = '0;
            case (r.action)
                tcw_pkg::ACT_PUT:
                begin
                    if (r.character != '0)
                    begin
                        if (r.character == tcw_pkg::NEWLINE_CHAR)
                            cursor = (cursor / tcw_pkg::COLUMNS + 1) * tcw_pkg::COLUMNS;
                        else
                        begin
                            cells[cursor] = {attr, r.character};
                            cursor++;
                        end
                        if (cursor >= tcw_pkg::CELL_COUNT)
                        begin
                            for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
                                cells[i] = cells[i + tcw_pkg::COLUMNS];
                            for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS;
                                 i < tcw_pkg::CELL_COUNT; i++)
                                cells[i] = {attr, tcw_pkg::SPACE_CHAR};
                            cursor -= tcw_pkg::COLUMNS;
                            outcome.scrolled = 1'b1;
                        end
                    end
                end
                tcw_pkg::ACT_CLEAR:
                begin
                    foreach (cells[i])
                        cells[i] = {attr, tcw_pkg::SPACE_CHAR};
                    cursor = 0;
                end
                tcw_pkg::ACT_READ:
                begin
                    if (int'(r.cell_index) < tcw_pkg::CELL_COUNT)
                        {outcome.read_attribute, outcome.read_character} = cells[r.cell_index];
                end
                default:
                begin
                end
            endcase
            outcome.cursor_cell = tcw_pkg::CURSOR_W'(cursor);
            due_results.push_back(outcome);
        endfunction

        function void compare_result(tcw_pkg::result_t got);
            tcw_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with no transaction outstanding: cursor_cell %0d",
                       got.cursor_cell);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.cursor_cell !== want.cursor_cell)
            begin
                $error("cursor_cell: expected %0d, actual %0d", want.cursor_cell,
                       got.cursor_cell);
                errors++;
            end
            if (got.read_character !== want.read_character)
            begin
                $error("read_character: expected %0d, actual %0d", want.read_character,
                       got.read_character);
                errors++;
            end
            if (got.read_attribute !== want.read_attribute)
            begin
                $error("read_attribute: expected %0d, actual %0d", want.read_attribute,
                       got.read_attribute);
                errors++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    tcw_pkg::request_t          request;
    logic                       done;
    tcw_pkg::result_t           result;
    logic                       cfg_we;
    logic [tcw_pkg::ATTR_W-1:0] cfg_wdata;

    console_mirror mirror = new();
    longint        cycles = 0;
    bit            sender_eager = 0;

    text_console_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n)
        begin
            if (done)
                mirror.compare_result(result);
            if (start && !busy)
                mirror.apply_request(request);
            if (cfg_we)
                mirror.attr = cfg_wdata;
        end
    end

    function automatic tcw_pkg::request_t make_request(
        logic [tcw_pkg::ACTION_W-1:0] act,
        logic [tcw_pkg::CHAR_W-1:0]   ch,
        logic [tcw_pkg::INDEX_W-1:0]  idx);
        tcw_pkg::request_t r;
        r.action     = act;
        r.character  = ch;
        r.cell_index = idx;
        return r;
    endfunction

    function automatic tcw_pkg::request_t random_request();
        int                pick;
        int                near;
        tcw_pkg::request_t r;
        pick = int'($urandom_range(0, 999));
        r.action     = tcw_pkg::ACT_PUT;
        r.character  = tcw_pkg::CHAR_W'($urandom);
        r.cell_index = tcw_pkg::INDEX_W'($urandom);
        if (pick < 3)
            r.action = tcw_pkg::ACT_CLEAR;
        else if (pick < 130)
            r.character = tcw_pkg::NEWLINE_CHAR;
        else if (pick < 300)
        begin
            r.action = tcw_pkg::ACT_READ;
            case ($urandom_range(0, 9))
                0:
                    r.cell_index = tcw_pkg::INDEX_W'($urandom_range(tcw_pkg::CELL_COUNT,
                                                     2 ** tcw_pkg::INDEX_W - 1));
                1, 2, 3:
                    r.cell_index = tcw_pkg::INDEX_W'($urandom_range(0,
                                                     tcw_pkg::CELL_COUNT - 1));
                default:
                begin
                    near = mirror.cursor - int'($urandom_range(0, tcw_pkg::COLUMNS + 1));
                    r.cell_index = (near < 0) ? '0 : tcw_pkg::INDEX_W'(near);
                end
            endcase
        end
        else if (pick < 315)
            r.action = ACT_UNUSED;
        else if (pick < 330)
            r.character = 8'h00;
        else if ($urandom_range(0, 4) == 0)
            r.character = tcw_pkg::CHAR_W'($urandom_range(1, 255));
        else
            r.character = tcw_pkg::CHAR_W'($urandom_range(32, 126));
        return r;
    endfunction

    task automatic send_request(input tcw_pkg::request_t r);
        int gap;
        gap = sender_eager ? 0 : int'($urandom_range(0, 15));
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request = r;
        start   = 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (mirror.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        logic [tcw_pkg::ATTR_W-1:0] attr_plan [PHASES];
        attr_plan = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F, 8'h00};
        attr_plan[3] = tcw_pkg::ATTR_W'($urandom);
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(make_request(tcw_pkg::ACT_READ, 8'h00, 11'd0));
        send_request(make_request(tcw_pkg::ACT_READ, 8'hFF,
                                  tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT - 1)));
        send_request(make_request(tcw_pkg::ACT_READ, 8'h00,
                                  tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT)));
        send_request(make_request(tcw_pkg::ACT_READ, 8'hFF, 11'h7FF));
        send_request(make_request(tcw_pkg::ACT_PUT, 8'h48, 11'd0));
        send_request(make_request(tcw_pkg::ACT_PUT, 8'hFF, 11'h7FF));
        send_request(make_request(tcw_pkg::ACT_PUT, 8'h00, 11'h7FF));
        send_request(make_request(tcw_pkg::ACT_READ, 8'h00, 11'd0));
        send_request(make_request(tcw_pkg::ACT_READ, 8'h00, 11'd1));
        send_request(make_request(ACT_UNUSED, 8'hFF, 11'h7FF));
        for (int i = 0; i < tcw_pkg::ROWS; i++)
            send_request(make_request(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0));
        send_request(make_request(tcw_pkg::ACT_READ, 8'h00, 11'd0));
        send_request(make_request(tcw_pkg::ACT_CLEAR, 8'hFF, 11'h7FF));
        send_request(make_request(tcw_pkg::ACT_READ, 8'h00,
                                  tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT - 1)));

        for (int p = 0; p < PHASES; p++)
        begin
            write_attribute(attr_plan[p]);
            sender_eager = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
        end

        drain();
        repeat (8) @(posedge clk);
        if (mirror.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
